[sv/wrp_pkg.sv]
// Shared constants for the weighted random entry picker: field widths,
// operation, status and group kind codes. No dependencies.
package wrp_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int ID_BITS_DEF     = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int RAND_BITS   = 32;
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;
  localparam int KIND_BITS   = 2;

  localparam logic [OP_BITS-1:0] OP_ADD_SINGLE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADD_PAIR   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DRAW       = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DRAWN    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_MISMATCH = 3'd4;

  localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SINGLE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_PAIR   = 2'd2;

endpackage

[sv/wrp_table.sv]
// Entry table of the picker: one synchronous memory holding weight and ids.
// One write port and one read port with registered read data; uses wrp_pkg.
module wrp_table
  import wrp_pkg::*;
#(
  parameter int DEPTH     = MAX_ENTRIES_DEF,
  parameter int DATA_BITS = WEIGHT_BITS_DEF + 2 * ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_BITS-1:0]     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_BITS-1:0]     rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/wrp_scale.sv]
// Bit-serial scaler: point = floor(rand * total / 2^32), one random bit a cycle.
// Uses wrp_pkg for the random fraction width.
module wrp_scale
  import wrp_pkg::*;
#(
  parameter int TOTAL_BITS = WEIGHT_BITS_DEF + 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RAND_BITS-1:0]  rand_in,
  input  logic [TOTAL_BITS-1:0] total,
  output logic                  done,
  output logic [TOTAL_BITS-1:0] point
);

  localparam int STEP_BITS = $clog2(RAND_BITS);

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic [RAND_BITS-1:0]  rand_sr;
  logic [TOTAL_BITS-1:0] tot;
  logic [TOTAL_BITS:0]   sum;

  // Least significant bit first: add, then halve. The dropped bits make the
  // final value the exact floor of the product over 2^32.
  assign sum = {1'b0, point} + (rand_sr[0] ? {1'b0, tot} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        step    <= '0;
        rand_sr <= rand_in;
        tot     <= total;
        point   <= '0;
      end else if (busy) begin
        point   <= sum[TOTAL_BITS:1];
        rand_sr <= rand_sr >> 1;
        step    <= step + 1'b1;
        if (step == STEP_BITS'(RAND_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/weighted_random_entry_picker.sv]
// Weighted random entry picker (roulette wheel); uses wrp_pkg, wrp_table, wrp_scale.
// An add or an empty draw goes straight to the output register; a draw first scales the
// random value, then walks the table with one read per entry until an entry's weight covers
// the point, and falls back to entry zero when the walk matches nothing.
// One item is in work at a time; a result still held in the output register stalls the next.
// Reset (synchronous, active high) empties the table, clears the total weight and group kind, and returns to idle.
module weighted_random_entry_picker
  import wrp_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // Input stream.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata fields from bit 0: weight, first_id, second_id, random_value, zero pad.
  input  logic [((WEIGHT_BITS+2*ID_BITS+RAND_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser fields from bit 0: op.
  input  logic [OP_BITS-1:0] s_axis_tuser,
  // Result stream.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata fields from bit 0: picked_first, picked_second, group_kind, zero pad.
  output logic [((2*ID_BITS+KIND_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser fields from bit 0: status.
  output logic [STATUS_BITS-1:0] m_axis_tuser
);

  localparam int ADDR_BITS  = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
  // Wide enough for every entry at full weight, so the total never wraps.
  localparam int TOTAL_BITS = WEIGHT_BITS + ADDR_BITS;
  localparam int ENTRY_BITS = WEIGHT_BITS + 2 * ID_BITS;
  localparam int OUT_BITS   = 2 * ID_BITS + KIND_BITS;
  localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_WALK,
    S_FIN
  } state_t;

  state_t state;

  // Input field unpacking.
  logic [OP_BITS-1:0]     in_op;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [ID_BITS-1:0]     in_first;
  logic [ID_BITS-1:0]     in_second;
  logic [RAND_BITS-1:0]   in_rand;

  assign in_op     = s_axis_tuser;
  assign in_weight = s_axis_tdata[WEIGHT_BITS-1:0];
  assign in_first  = s_axis_tdata[WEIGHT_BITS +: ID_BITS];
  assign in_second = s_axis_tdata[WEIGHT_BITS+ID_BITS +: ID_BITS];
  assign in_rand   = s_axis_tdata[WEIGHT_BITS+2*ID_BITS +: RAND_BITS];

  // Table bookkeeping.
  logic [CNT_BITS-1:0]   entry_count;
  logic [TOTAL_BITS-1:0] total_weight;
  logic [KIND_BITS-1:0]  kind_reg;

  // Result waiting for the output register.
  logic [STATUS_BITS-1:0] res_status;
  logic [ID_BITS-1:0]     res_first;
  logic [ID_BITS-1:0]     res_second;

  // Output register.
  logic [STATUS_BITS-1:0] out_status;
  logic [ID_BITS-1:0]     out_first;
  logic [ID_BITS-1:0]     out_second;
  logic [KIND_BITS-1:0]   out_kind;

  // Walk state.
  logic [CNT_BITS-1:0]   issue_cnt;
  logic                  pend;
  logic                  fb_taken;
  logic [TOTAL_BITS-1:0] point;
  logic [ID_BITS-1:0]    fb_first;
  logic [ID_BITS-1:0]    fb_second;

  // Decoded input transfer.
  logic                 in_xfer;
  logic                 is_add;
  logic [KIND_BITS-1:0] want_kind;
  logic                 table_full;
  logic                 kind_clash;
  logic                 add_ok;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  // Codes other than the two adds are draws; the unused top code draws too.
  assign is_add        = (in_op == OP_ADD_SINGLE) || (in_op == OP_ADD_PAIR);
  assign want_kind     = (in_op == OP_ADD_PAIR) ? KIND_PAIR : KIND_SINGLE;
  assign table_full    = (entry_count == CNT_BITS'(MAX_ENTRIES));
  assign kind_clash    = (kind_reg != KIND_NONE) && (kind_reg != want_kind);
  assign add_ok        = in_xfer && is_add && !table_full && !kind_clash;

  // Memory ports. Writes happen only while idle and reads only during a
  // walk, so the two never touch the same entry in overlapping cycles.
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [ID_BITS-1:0]     rd_first;
  logic [ID_BITS-1:0]     rd_second;

  assign wr_en   = add_ok;
  assign wr_addr = entry_count[ADDR_BITS-1:0];
  // A single entry stores a zero second id.
  assign wr_data = {(want_kind == KIND_PAIR) ? in_second : ID_BITS'(0), in_first, in_weight};

  assign rd_en   = (state == S_WALK) && (issue_cnt < entry_count);
  assign rd_addr = issue_cnt[ADDR_BITS-1:0];

  assign rd_weight = rd_data[WEIGHT_BITS-1:0];
  assign rd_first  = rd_data[WEIGHT_BITS +: ID_BITS];
  assign rd_second = rd_data[WEIGHT_BITS+ID_BITS +: ID_BITS];

  wrp_table #(
    .DEPTH     (MAX_ENTRIES),
    .DATA_BITS (ENTRY_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Draw point scaler, started by the input transfer of a draw on a non-empty table.
  logic                  scale_start;
  logic                  scale_done;
  logic [TOTAL_BITS-1:0] scale_point;

  assign scale_start = in_xfer && !is_add && (entry_count != '0);

  wrp_scale #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .start   (scale_start),
    .rand_in (in_rand),
    .total   (total_weight),
    .done    (scale_done),
    .point   (scale_point)
  );

  // The walk keeps one read in flight: the entry read in one cycle is
  // compared in the next while the following address is already issued.
  // A match ends the walk; the read issued behind it is simply dropped.
  // Entry zero's ids are captured on the way past as the fallback for a
  // walk that matches nothing, which happens when every weight is zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      entry_count   <= '0;
      total_weight  <= '0;
      kind_reg      <= KIND_NONE;
      pend          <= 1'b0;
      fb_taken      <= 1'b0;
    end else begin
      // In the final state the output register is either reloaded or still
      // waiting for the receiver, so it is only emptied elsewhere.
      if (m_axis_tready && (state != S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            res_first  <= '0;
            res_second <= '0;
            if (is_add) begin
              state <= S_FIN;
              priority if (table_full) begin
                res_status <= ST_FULL;
              end else if (kind_clash) begin
                res_status <= ST_MISMATCH;
              end else begin
                res_status   <= ST_ADDED;
                entry_count  <= entry_count + 1'b1;
                total_weight <= total_weight + TOTAL_BITS'(in_weight);
                kind_reg     <= want_kind;
              end
            end else if (entry_count == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_FIN;
            end else begin
              res_status <= ST_DRAWN;
              state      <= S_SCALE;
            end
          end
        end

        S_SCALE: begin
          if (scale_done) begin
            point     <= scale_point;
            issue_cnt <= '0;
            pend      <= 1'b0;
            fb_taken  <= 1'b0;
            state     <= S_WALK;
          end
        end

        S_WALK: begin
          pend <= rd_en;
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (pend) begin
            if (!fb_taken) begin
              fb_first  <= rd_first;
              fb_second <= rd_second;
              fb_taken  <= 1'b1;
            end
            if (point < TOTAL_BITS'(rd_weight)) begin
              res_first  <= rd_first;
              res_second <= rd_second;
              state      <= S_FIN;
            end else begin
              point <= point - TOTAL_BITS'(rd_weight);
            end
          end else if (!rd_en) begin
            res_first  <= fb_first;
            res_second <= fb_second;
            state      <= S_FIN;
          end
        end

        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_first     <= res_first;
            out_second    <= (kind_reg == KIND_PAIR) ? res_second : '0;
            out_kind      <= kind_reg;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = OUT_TDATA'({out_kind, out_second, out_first});

endmodule
